@@ design/tccw_pkg.sv @@
// Shared definitions for the text console character writer: field widths,
// codes, control characters and the UTF-8 decoder helper functions.
// No dependencies.
package tccw_pkg;

   // Default screen limits handed to the top level as parameter defaults.
   localparam int MAX_COLS_DEF = 128;
   localparam int MAX_ROWS_DEF = 64;

   // Register file.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] REG_COLUMNS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ROWS    = 1'd1;
   localparam logic [7:0] COLUMNS_RESET = 8'd80;
   localparam logic [6:0] ROWS_RESET    = 7'd25;

   // Request operations.
   localparam logic OP_BYTE   = 1'b0;
   localparam logic OP_CURSOR = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_SCROLL = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_REPORT = 2'd2;

   // Control characters handled by the cursor logic, the fill character and tab stop.
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_BS  = 8'h08;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_BEL = 8'h07;
   localparam logic [20:0] FILL_CHAR = 21'd32;
   localparam int TAB_STOP = 8;

   // UTF-8 decoder states.
   localparam logic [3:0] ST_ACCEPT = 4'd0;
   localparam logic [3:0] ST_REJECT = 4'd1;
   localparam logic [3:0] ST_NEED1  = 4'd2;
   localparam logic [3:0] ST_NEED2  = 4'd3;
   localparam logic [3:0] ST_E0     = 4'd4;
   localparam logic [3:0] ST_ED     = 4'd5;
   localparam logic [3:0] ST_F0     = 4'd6;
   localparam logic [3:0] ST_NEED3  = 4'd7;
   localparam logic [3:0] ST_F4     = 4'd8;

   // Next decoder state for one byte.
   function automatic logic [3:0] dfa_next(input logic [3:0] st, input logic [7:0] b);
      logic cont;
      logic [3:0] ns;
      cont = (b >= 8'h80) && (b <= 8'hBF);
      ns   = ST_REJECT;
      case (st)
         ST_ACCEPT: begin
            if (b < 8'h80)                       ns = ST_ACCEPT;
            else if (b inside {[8'hC2:8'hDF]})   ns = ST_NEED1;
            else if (b == 8'hE0)                 ns = ST_E0;
            else if (b == 8'hED)                 ns = ST_ED;
            else if (b inside {[8'hE1:8'hEF]})   ns = ST_NEED2;
            else if (b == 8'hF0)                 ns = ST_F0;
            else if (b inside {[8'hF1:8'hF3]})   ns = ST_NEED3;
            else if (b == 8'hF4)                 ns = ST_F4;
            else                                 ns = ST_REJECT;
         end
         ST_NEED1: ns = cont ? ST_ACCEPT : ST_REJECT;
         ST_NEED2: ns = cont ? ST_NEED1 : ST_REJECT;
         ST_E0:    ns = (b inside {[8'hA0:8'hBF]}) ? ST_NEED1 : ST_REJECT;
         ST_ED:    ns = (b inside {[8'h80:8'h9F]}) ? ST_NEED1 : ST_REJECT;
         ST_F0:    ns = (b inside {[8'h90:8'hBF]}) ? ST_NEED2 : ST_REJECT;
         ST_NEED3: ns = cont ? ST_NEED2 : ST_REJECT;
         ST_F4:    ns = (b inside {[8'h80:8'h8F]}) ? ST_NEED2 : ST_REJECT;
         default:  ns = ST_REJECT;
      endcase
      return ns;
   endfunction

   // Payload bits carried by the first byte of a sequence.
   function automatic logic [20:0] lead_bits(input logic [7:0] b);
      logic [20:0] r;
      r = '0;
      if (b < 8'h80)                      r = {13'd0, b};
      else if (b inside {[8'hC0:8'hDF]})  r = {16'd0, b[4:0]};
      else if (b inside {[8'hE0:8'hEF]})  r = {17'd0, b[3:0]};
      else if (b inside {[8'hF0:8'hF7]})  r = {18'd0, b[2:0]};
      else                                r = '0;
      return r;
   endfunction

endpackage

@@ design/text_console_char_writer_top.sv @@
// Top level of the text console character writer: request register, cursor
// and UTF-8 decode logic, and the result set that is played out beat by beat.
// Depends on tccw_pkg.

// Each request beat (an output byte or a cursor load) produces one to three
// result beats: zero, one or two scroll-up commands, at most one cell write,
// and always a closing cursor report with last set. The block takes one
// request into an input register, evaluates it combinationally against the
// cursor, the decoder state and the screen size, and stores the outcome as a
// result set; the set then leaves one beat per cycle unless rsp_stall holds
// it. A request therefore occupies the result side for one beat per result,
// one to three; that output beat rate is what bounds throughput. The next
// request is taken into the input register while the current set still drains,
// so a waiting result never blocks the request side by more than that one slot.
// The columns and rows registers are clamped to 1..MAX_COLS and 1..MAX_ROWS
// when used; write them only while the block is idle. Reset is synchronous
// and needs no clearing time.
module text_console_char_writer_top #(
   parameter int MAX_COLS = tccw_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = tccw_pkg::MAX_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic                              csr_wr_en,
   input  logic [tccw_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tccw_pkg::CSR_DATA_W-1:0]   csr_wr_data,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_data_byte,
   input  logic [31:0] req_fg_color,
   input  logic [31:0] req_bg_color,
   input  logic [7:0]  req_attr_flags,
   input  logic [7:0]  req_new_col,
   input  logic [5:0]  req_new_row,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_col,
   output logic [5:0]  rsp_row,
   output logic [20:0] rsp_code_point,
   output logic [31:0] rsp_cell_fg,
   output logic [31:0] rsp_cell_bg,
   output logic [7:0]  rsp_cell_flags,
   output logic        rsp_last
);

   // Clamp limits in the widths of the registers they are compared with.
   localparam logic [7:0] COLS_LIMIT = 8'(MAX_COLS);
   localparam logic [7:0] ROWS_LIMIT = 8'(MAX_ROWS);

   // Configuration registers.
   logic [7:0] columns_ff;
   logic [6:0] rows_ff;

   // Block state.
   logic [7:0]  cur_col_ff, cur_col_in;
   logic [5:0]  cur_row_ff, cur_row_in;
   logic [3:0]  utf8_ff, utf8_in;
   logic [20:0] partial_ff, partial_in;

   // Request register.
   logic        pend_valid_ff, pend_valid_in;
   logic        in_op_ff;
   logic [7:0]  in_byte_ff;
   logic [31:0] in_fg_ff, in_bg_ff;
   logic [7:0]  in_flags_ff;
   logic [7:0]  in_new_col_ff;
   logic [5:0]  in_new_row_ff;

   // Result set: everything needed to replay the beats of one request.
   logic        set_valid_ff, set_valid_in;
   logic [1:0]  beat_ff, beat_in;
   logic [1:0]  set_nscroll_ff;
   logic        set_wr_ff;
   logic [7:0]  set_wr_col_ff;
   logic [5:0]  set_wr_row_ff;
   logic [20:0] set_cp_ff;
   logic [31:0] set_fg_ff, set_bg_ff;
   logic [7:0]  set_flags_ff;
   logic [7:0]  set_cur_col_ff;
   logic [5:0]  set_cur_row_ff;

   // Handshake.
   logic       req_take, rsp_take, set_done, set_free, move;
   logic [1:0] last_beat;

   // Evaluation temporaries.
   logic [7:0]  cols_v, rws_v;
   logic [7:0]  x_v;
   logic [5:0]  y_v;
   logic [7:0]  ywide_v;
   logic [8:0]  tab_v;
   logic [3:0]  ns_v;
   logic [1:0]  nscroll_v;
   logic        wr_v;
   logic [7:0]  wr_col_v;
   logic [5:0]  wr_row_v;

   // The result set frees up in the cycle its report beat is taken, so a
   // waiting request moves in without a bubble.
   assign last_beat = set_nscroll_ff + {1'b0, set_wr_ff};
   assign rsp_valid = set_valid_ff;
   assign rsp_take  = set_valid_ff && !rsp_stall;
   assign set_done  = rsp_take && (beat_ff == last_beat);
   assign set_free  = !set_valid_ff || set_done;
   assign move      = pend_valid_ff && set_free;
   assign req_stall = pend_valid_ff && !set_free;
   assign req_take  = req_valid && !req_stall;

   assign pend_valid_in = req_take || (pend_valid_ff && !move);
   assign set_valid_in  = move || (set_valid_ff && !set_done);

   always_comb begin
      if (move) begin
         beat_in = 2'd0;
      end else if (rsp_take) begin
         beat_in = beat_ff + 2'd1;
      end else begin
         beat_in = beat_ff;
      end
   end

   // Screen size in use, clamped to the supported range.
   always_comb begin
      if (columns_ff == 8'd0) begin
         cols_v = 8'd1;
      end else if (columns_ff > COLS_LIMIT) begin
         cols_v = COLS_LIMIT;
      end else begin
         cols_v = columns_ff;
      end
      if (rows_ff == 7'd0) begin
         rws_v = 8'd1;
      end else if ({1'b0, rows_ff} > ROWS_LIMIT) begin
         rws_v = ROWS_LIMIT;
      end else begin
         rws_v = {1'b0, rows_ff};
      end
   end

   // One request against the cursor and decoder. Except on CR, a pending wrap is
   // resolved first, which may scroll; a line feed at the bottom scrolls again.
   always_comb begin
      x_v        = cur_col_ff;
      y_v        = cur_row_ff;
      ywide_v    = '0;
      tab_v      = '0;
      nscroll_v  = 2'd0;
      wr_v       = 1'b0;
      wr_col_v   = cur_col_ff;
      wr_row_v   = cur_row_ff;
      ns_v       = tccw_pkg::dfa_next(utf8_ff, in_byte_ff);
      utf8_in    = utf8_ff;
      partial_in = partial_ff;
      if (in_op_ff == tccw_pkg::OP_CURSOR) begin
         x_v = in_new_col_ff;
         y_v = in_new_row_ff;
      end else begin
         if (utf8_ff != tccw_pkg::ST_ACCEPT) begin
            partial_in = {partial_ff[14:0], in_byte_ff[5:0]};
         end else begin
            partial_in = tccw_pkg::lead_bits(in_byte_ff);
         end
         // A rejected sequence drops back to the start state.
         utf8_in = (ns_v == tccw_pkg::ST_REJECT) ? tccw_pkg::ST_ACCEPT : ns_v;
         if (ns_v == tccw_pkg::ST_ACCEPT) begin
            if (in_byte_ff == tccw_pkg::CHAR_CR) begin
               x_v = 8'd0;
            end else begin
               ywide_v = {2'b00, y_v};
               if (x_v == cols_v) begin
                  x_v     = 8'd0;
                  ywide_v = ywide_v + 8'd1;
               end
               if (ywide_v == rws_v) begin
                  nscroll_v = 2'd1;
                  ywide_v   = rws_v - 8'd1;
               end
               y_v = ywide_v[5:0];
               case (in_byte_ff)
                  tccw_pkg::CHAR_LF: begin
                     ywide_v = {2'b00, y_v} + 8'd1;
                     if (ywide_v == rws_v) begin
                        nscroll_v = nscroll_v + 2'd1;
                        ywide_v   = rws_v - 8'd1;
                     end
                     y_v = ywide_v[5:0];
                  end
                  tccw_pkg::CHAR_BEL: begin
                     x_v = x_v;
                  end
                  tccw_pkg::CHAR_BS: begin
                     if (x_v != 8'd0) begin
                        x_v = x_v - 8'd1;
                     end
                  end
                  tccw_pkg::CHAR_TAB: begin
                     tab_v = {1'b0, x_v} + 9'(tccw_pkg::TAB_STOP) - {6'd0, x_v[2:0]};
                     if (tab_v > {1'b0, cols_v}) begin
                        x_v = cols_v;
                     end else begin
                        x_v = tab_v[7:0];
                     end
                  end
                  default: begin
                     // Printable: write only when the cursor is on screen,
                     // but always advance.
                     if ((x_v < cols_v) && ({2'b00, y_v} < rws_v)) begin
                        wr_v     = 1'b1;
                        wr_col_v = x_v;
                        wr_row_v = y_v;
                     end
                     x_v = x_v + 8'd1;
                  end
               endcase
            end
         end
      end
      cur_col_in = x_v;
      cur_row_in = y_v;
   end

   // Beat selection from the stored result set: scrolls, then the cell
   // write, then the cursor report.
   always_comb begin
      rsp_kind       = tccw_pkg::KIND_REPORT;
      rsp_col        = set_cur_col_ff;
      rsp_row        = set_cur_row_ff;
      rsp_code_point = '0;
      rsp_cell_fg    = '0;
      rsp_cell_bg    = '0;
      rsp_cell_flags = '0;
      rsp_last       = 1'b1;
      if (beat_ff < set_nscroll_ff) begin
         rsp_kind       = tccw_pkg::KIND_SCROLL;
         rsp_col        = '0;
         rsp_row        = '0;
         rsp_code_point = tccw_pkg::FILL_CHAR;
         rsp_cell_fg    = set_fg_ff;
         rsp_cell_bg    = set_bg_ff;
         rsp_cell_flags = set_flags_ff;
         rsp_last       = 1'b0;
      end else if ((beat_ff == set_nscroll_ff) && set_wr_ff) begin
         rsp_kind       = tccw_pkg::KIND_WRITE;
         rsp_col        = set_wr_col_ff;
         rsp_row        = set_wr_row_ff;
         rsp_code_point = set_cp_ff;
         rsp_cell_fg    = set_fg_ff;
         rsp_cell_bg    = set_bg_ff;
         rsp_cell_flags = set_flags_ff;
         rsp_last       = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff    <= tccw_pkg::COLUMNS_RESET;
         rows_ff       <= tccw_pkg::ROWS_RESET;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         utf8_ff       <= tccw_pkg::ST_ACCEPT;
         partial_ff    <= '0;
         pend_valid_ff <= 1'b0;
         set_valid_ff  <= 1'b0;
         beat_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               tccw_pkg::REG_COLUMNS: columns_ff <= csr_wr_data;
               tccw_pkg::REG_ROWS:    rows_ff    <= csr_wr_data[6:0];
               default:               columns_ff <= columns_ff;
            endcase
         end
         if (move) begin
            cur_col_ff <= cur_col_in;
            cur_row_ff <= cur_row_in;
            utf8_ff    <= utf8_in;
            partial_ff <= partial_in;
         end
         pend_valid_ff <= pend_valid_in;
         set_valid_ff  <= set_valid_in;
         beat_ff       <= beat_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff      <= req_op;
         in_byte_ff    <= req_data_byte;
         in_fg_ff      <= req_fg_color;
         in_bg_ff      <= req_bg_color;
         in_flags_ff   <= req_attr_flags;
         in_new_col_ff <= req_new_col;
         in_new_row_ff <= req_new_row;
      end
      if (move) begin
         set_nscroll_ff <= nscroll_v;
         set_wr_ff      <= wr_v;
         set_wr_col_ff  <= wr_col_v;
         set_wr_row_ff  <= wr_row_v;
         set_cp_ff      <= partial_in;
         set_fg_ff      <= in_fg_ff;
         set_bg_ff      <= in_bg_ff;
         set_flags_ff   <= in_flags_ff;
         set_cur_col_ff <= cur_col_in;
         set_cur_row_ff <= cur_row_in;
      end
   end

endmodule
